FILE: hw/rtl/fpc_pkg.sv
package fpc_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_PLANE,
        S_RD0,
        S_RDW,
        S_RDW2,
        S_EDGE,
        S_TSET,
        S_TCHK,
        S_DIV,
        S_DDONE,
        S_LMUL,
        S_LADD,
        S_FIX,
        S_PUSHC,
        S_ADV,
        S_OSTART,
        S_ORD,
        S_OGET,
        S_OX,
        S_PMUL,
        S_PLOAD,
        S_OSEND,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic [4:0]       code;
        logic [8:0][31:0] f;
    } t_vtx;

    localparam int NUM_FIELDS = 9;
    localparam int LAST_FIELD = NUM_FIELDS - 1;

    localparam logic signed [31:0] NEAR_Z = 32'sd655;
    localparam logic [28:0] T_ONE = 29'h1000_0000;
    localparam logic signed [63:0] T_HALF = 64'sd134217728;
    localparam logic [4:0] DIV_LAST = 5'd28;

    localparam logic [2:0] PL_XP = 3'd0;
    localparam logic [2:0] PL_XN = 3'd1;
    localparam logic [2:0] PL_YP = 3'd2;
    localparam logic [2:0] PL_YN = 3'd3;
    localparam logic [2:0] PL_NEAR = 3'd4;

    localparam logic [1:0] MARK_MORE = 2'd0;
    localparam logic [1:0] MARK_LAST = 2'd1;
    localparam logic [1:0] MARK_EMPTY = 2'd2;

    localparam logic REG_HALF_WIDTH = 1'b0;

    localparam logic [11:0] HALF_WIDTH_RST = 12'd320;
    localparam logic [11:0] HALF_HEIGHT_RST = 12'd240;

    function automatic logic [4:0] f_outcode(input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z);
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        logic signed [32:0] zs;
        logic signed [32:0] sxz;
        logic signed [32:0] syz;
        logic [4:0]         r;
        xs = {x[31], x};
        ys = {y[31], y};
        zs = {z[31], z};
        sxz = xs + zs;
        syz = ys + zs;
        r[0] = xs > zs;
        r[1] = sxz[32];
        r[2] = ys > zs;
        r[3] = syz[32];
        r[4] = z < NEAR_Z;
        return r;
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -36'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] f_negsat(input logic signed [31:0] v);
        logic [31:0] r;
        if (v == 32'sh8000_0000) begin
            r = 32'h7fff_ffff;
        end else begin
            r = 32'(-v);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/frustum_polygon_clipper_core.sv
// each vertex is loaded through S_IDLE and S_LOAD; on the last vertex each clipped plane walks
//   its edges, and a crossing may use the 29-step divider and takes 9 lerps on the shared multiplier
// output: each vertex is read from the buffer, with two 29-step divisions when projected
// one polygon in flight; the shared divider and multiplier and output back-pressure set the rate
// synchronous active-low reset; vertex memory contents are not cleared
module frustum_polygon_clipper_core #(
    parameter int MAX_IN_VERTS = 8,
    parameter int BUF_VERTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vert_x, vert_y, vert_z, tex_s, tex_t, col_r, col_g, col_b, col_a
    input  logic [287:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z, out_s, out_t, out_r, out_g, out_b, out_a, screen_x, screen_y
    output logic [351:0] m_axis_tdata,
    // end_mark
    output logic [1:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IN_CAP = (MAX_IN_VERTS < BUF_VERTS) ? MAX_IN_VERTS : BUF_VERTS;
    localparam int OUT_LIMIT = MAX_IN_VERTS + 5;
    localparam int IW = $clog2(BUF_VERTS);
    localparam int CW = $clog2(BUF_VERTS + 1);
    localparam int AW = $clog2(2 * BUF_VERTS);
    localparam int DEPTH = 2 * BUF_VERTS;

    function automatic logic [AW-1:0] f_addr(input logic b, input logic [IW-1:0] ix);
        return AW'(ix) + (b ? AW'(BUF_VERTS) : AW'(0));
    endfunction

    fpc_pkg::t_state r_state, n_state;

    logic [11:0]      r_hw, r_hh;
    logic [CW-1:0]    r_cnt [2];
    logic [CW-1:0]    n_cnt [2];
    logic [4:0]       r_or, n_or, r_and, n_and;
    logic             r_buf, n_buf, r_last, n_last;
    logic [2:0]       r_plane, n_plane;
    logic [CW-1:0]    r_i, n_i, r_n, n_n;
    logic [3:0]       r_k, n_k;
    logic             r_mode, n_mode, r_axis, n_axis, r_neg, n_neg;
    logic [4:0]       r_dcnt, n_dcnt;
    logic             r_ovalid, n_ovalid;

    fpc_pkg::t_vtx    r_v, n_v, r_w, n_w, r_first, n_first, r_c, n_c, r_rd;
    logic signed [35:0] r_num, n_num, r_den, n_den;
    logic [28:0]      r_t, n_t, r_nlo, n_nlo, r_quo, n_quo;
    logic [34:0]      r_rem, n_rem, r_dvs, n_dvs;
    logic signed [63:0] r_prod, n_prod;
    logic [31:0]      r_sx, n_sx, r_sy, n_sy;
    logic [351:0]     r_odata, n_odata;
    logic [1:0]       r_ouser, n_ouser;

    fpc_pkg::t_vtx    mem [DEPTH];
    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    fpc_pkg::t_vtx    w_wdata;

    logic             push_en, push_b;
    fpc_pkg::t_vtx    push_d;

    logic             w_dst, w_accept, w_nlast, w_out_free, w_c0, w_c1, w_ge;
    logic [4:0]       w_code_in, w_code_c;
    logic [36:0]      w_trial;
    logic signed [33:0] w_mul_a;
    logic signed [29:0] w_mul_b;
    logic signed [63:0] w_prod, w_round;
    logic signed [31:0] w_a, w_b, w_sel, w_z;
    logic signed [32:0] w_d;
    logic signed [35:0] w_sum;
    logic [31:0]      w_mag, w_qs, w_pres;
    logic [11:0]      w_half;
    logic [CW-1:0]    w_i1, w_n0;

    assign w_dst = ~r_buf;
    assign w_accept = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (r_state == fpc_pkg::S_IDLE);
    assign w_i1 = r_i + CW'(1);
    assign w_nlast = (w_i1 == r_n);
    assign w_out_free = ~r_ovalid | m_axis_tready;
    assign w_c0 = r_v.code[r_plane];
    assign w_c1 = r_w.code[r_plane];
    assign w_n0 = r_cnt[r_buf];
    assign w_code_in = fpc_pkg::f_outcode(r_w.f[0], r_w.f[1], r_w.f[2]);
    assign w_code_c = fpc_pkg::f_outcode(r_c.f[0], r_c.f[1], r_c.f[2]);

    assign w_trial = {1'b0, r_rem, r_nlo[28]} - {2'b00, r_dvs};
    assign w_ge = ~w_trial[36];

    assign w_a = r_v.f[r_k];
    assign w_b = r_w.f[r_k];
    assign w_d = {w_b[31], w_b} - {w_a[31], w_a};
    assign w_half = r_axis ? r_hh : r_hw;
    assign w_sel = r_axis ? r_v.f[1] : r_v.f[0];
    assign w_z = r_v.f[2];
    assign w_mag = w_sel[31] ? 32'(-w_sel) : w_sel;

    always_comb begin
        if (r_state == fpc_pkg::S_PMUL) begin
            w_mul_a = {2'b00, w_mag};
            w_mul_b = {18'd0, w_half};
        end else begin
            w_mul_a = {w_d[32], w_d};
            w_mul_b = {1'b0, r_t};
        end
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_round = r_prod + fpc_pkg::T_HALF;
    assign w_sum = $signed(w_round[63:28]) + {{4{w_a[31]}}, w_a};
    assign w_qs = r_neg ? 32'd0 - {3'b000, r_quo} : {3'b000, r_quo};
    assign w_pres = w_qs + {4'b0000, w_half, 16'h0000};

    assign pready = 1'b1;
    assign prdata = {20'd0, (paddr[2] == fpc_pkg::REG_HALF_WIDTH) ? r_hw : r_hh};
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpc_pkg::S_IDLE:   if (w_accept) n_state = fpc_pkg::S_LOAD;
            fpc_pkg::S_LOAD:   n_state = r_last ? fpc_pkg::S_CHECK : fpc_pkg::S_IDLE;
            fpc_pkg::S_CHECK: begin
                if (w_n0 == '0 || r_and != 5'd0) n_state = fpc_pkg::S_EMPTY;
                else n_state = fpc_pkg::S_PLANE;
            end
            fpc_pkg::S_PLANE: begin
                if (r_or[r_plane] && w_n0 != '0) n_state = fpc_pkg::S_RD0;
                else if (r_plane == fpc_pkg::PL_XP) n_state = fpc_pkg::S_OSTART;
            end
            fpc_pkg::S_RD0:    n_state = fpc_pkg::S_RDW;
            fpc_pkg::S_RDW:    n_state = fpc_pkg::S_RDW2;
            fpc_pkg::S_RDW2:   n_state = fpc_pkg::S_EDGE;
            fpc_pkg::S_EDGE:   n_state = (w_c0 == w_c1) ? fpc_pkg::S_ADV : fpc_pkg::S_TSET;
            fpc_pkg::S_TSET:   n_state = fpc_pkg::S_TCHK;
            fpc_pkg::S_TCHK: begin
                if (r_den == '0 || r_num <= 0 || r_num >= r_den) n_state = fpc_pkg::S_LMUL;
                else n_state = fpc_pkg::S_DIV;
            end
            fpc_pkg::S_DIV:    if (r_dcnt == 5'd0) n_state = fpc_pkg::S_DDONE;
            fpc_pkg::S_DDONE: begin
                if (!r_mode) n_state = fpc_pkg::S_LMUL;
                else if (!r_axis) n_state = fpc_pkg::S_PMUL;
                else n_state = fpc_pkg::S_OSEND;
            end
            fpc_pkg::S_LMUL:   n_state = fpc_pkg::S_LADD;
            fpc_pkg::S_LADD: begin
                if (r_k == 4'(fpc_pkg::LAST_FIELD)) n_state = fpc_pkg::S_FIX;
                else n_state = fpc_pkg::S_LMUL;
            end
            fpc_pkg::S_FIX:    n_state = fpc_pkg::S_PUSHC;
            fpc_pkg::S_PUSHC:  n_state = fpc_pkg::S_ADV;
            fpc_pkg::S_ADV: begin
                if (!w_nlast) n_state = fpc_pkg::S_RDW;
                else if (r_plane == fpc_pkg::PL_XP) n_state = fpc_pkg::S_OSTART;
                else n_state = fpc_pkg::S_PLANE;
            end
            fpc_pkg::S_OSTART: n_state = (w_n0 == '0) ? fpc_pkg::S_EMPTY : fpc_pkg::S_ORD;
            fpc_pkg::S_ORD:    n_state = fpc_pkg::S_OGET;
            fpc_pkg::S_OGET:   n_state = fpc_pkg::S_OX;
            fpc_pkg::S_OX: begin
                if (r_v.code == 5'd0 && $signed(w_z) > 0) n_state = fpc_pkg::S_PMUL;
                else n_state = fpc_pkg::S_OSEND;
            end
            fpc_pkg::S_PMUL:   n_state = fpc_pkg::S_PLOAD;
            fpc_pkg::S_PLOAD:  n_state = fpc_pkg::S_DIV;
            fpc_pkg::S_OSEND: begin
                if (w_out_free) n_state = w_nlast ? fpc_pkg::S_IDLE : fpc_pkg::S_ORD;
            end
            fpc_pkg::S_EMPTY:  if (w_out_free) n_state = fpc_pkg::S_IDLE;
            default:           n_state = fpc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        n_or = r_or;
        n_and = r_and;
        n_buf = r_buf;
        n_last = r_last;
        n_plane = r_plane;
        n_i = r_i;
        n_n = r_n;
        n_k = r_k;
        n_mode = r_mode;
        n_axis = r_axis;
        n_neg = r_neg;
        n_dcnt = r_dcnt;
        n_ovalid = r_ovalid & ~m_axis_tready;
        n_v = r_v;
        n_w = r_w;
        n_first = r_first;
        n_c = r_c;
        n_num = r_num;
        n_den = r_den;
        n_t = r_t;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_nlo = r_nlo;
        n_quo = r_quo;
        n_prod = r_prod;
        n_sx = r_sx;
        n_sy = r_sy;
        n_odata = r_odata;
        n_ouser = r_ouser;
        push_en = 1'b0;
        push_b = r_buf;
        push_d = r_v;
        w_raddr = f_addr(r_buf, r_i[IW-1:0]);
        w_we = 1'b0;
        w_waddr = '0;
        w_wdata = r_v;

        case (r_state)
            fpc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_w.f = s_axis_tdata;
                    n_w.code = 5'd0;
                    n_last = s_axis_tlast;
                end
            end
            fpc_pkg::S_LOAD: begin
                if (r_cnt[r_buf] < CW'(IN_CAP)) begin
                    n_or = r_or | w_code_in;
                    n_and = r_and & w_code_in;
                    push_en = 1'b1;
                    push_d = r_w;
                    push_d.code = w_code_in;
                end
            end
            fpc_pkg::S_CHECK: begin
                n_plane = fpc_pkg::PL_NEAR;
            end
            fpc_pkg::S_PLANE: begin
                n_i = '0;
                n_n = w_n0;
                w_raddr = f_addr(r_buf, IW'(0));
                if (r_or[r_plane]) begin
                    n_cnt[w_dst] = '0;
                    if (w_n0 == '0) n_buf = w_dst;
                end
                if (!(r_or[r_plane] && w_n0 != '0) && r_plane != fpc_pkg::PL_XP) begin
                    n_plane = r_plane - 3'd1;
                end
            end
            fpc_pkg::S_RD0: begin
                n_v = r_rd;
                n_first = r_rd;
            end
            fpc_pkg::S_RDW: begin
                w_raddr = f_addr(r_buf, w_nlast ? IW'(0) : w_i1[IW-1:0]);
            end
            fpc_pkg::S_RDW2: begin
                n_w = w_nlast ? r_first : r_rd;
            end
            fpc_pkg::S_EDGE: begin
                if (!w_c0) begin
                    push_en = 1'b1;
                    push_b = w_dst;
                    push_d = r_v;
                end
                case (r_plane)
                    fpc_pkg::PL_XP: begin
                        n_num = 36'($signed(r_v.f[2])) - 36'($signed(r_v.f[0]));
                        n_den = (36'($signed(r_w.f[0])) - 36'($signed(r_v.f[0])))
                              - (36'($signed(r_w.f[2])) - 36'($signed(r_v.f[2])));
                    end
                    fpc_pkg::PL_XN: begin
                        n_num = 36'($signed(r_v.f[0])) + 36'($signed(r_v.f[2]));
                        n_den = -(36'($signed(r_w.f[0])) - 36'($signed(r_v.f[0])))
                              - (36'($signed(r_w.f[2])) - 36'($signed(r_v.f[2])));
                    end
                    fpc_pkg::PL_YP: begin
                        n_num = 36'($signed(r_v.f[2])) - 36'($signed(r_v.f[1]));
                        n_den = (36'($signed(r_w.f[1])) - 36'($signed(r_v.f[1])))
                              - (36'($signed(r_w.f[2])) - 36'($signed(r_v.f[2])));
                    end
                    fpc_pkg::PL_YN: begin
                        n_num = 36'($signed(r_v.f[1])) + 36'($signed(r_v.f[2]));
                        n_den = -(36'($signed(r_w.f[1])) - 36'($signed(r_v.f[1])))
                              - (36'($signed(r_w.f[2])) - 36'($signed(r_v.f[2])));
                    end
                    default: begin
                        n_num = 36'(fpc_pkg::NEAR_Z) - 36'($signed(r_v.f[2]));
                        n_den = 36'($signed(r_w.f[2])) - 36'($signed(r_v.f[2]));
                    end
                endcase
            end
            fpc_pkg::S_TSET: begin
                if (r_den[35]) begin
                    n_num = -r_num;
                    n_den = -r_den;
                end
            end
            fpc_pkg::S_TCHK: begin
                n_k = '0;
                n_mode = 1'b0;
                n_rem = r_num[35:1];
                n_nlo = {r_num[0], 28'd0};
                n_dvs = r_den[34:0];
                n_dcnt = fpc_pkg::DIV_LAST;
                if (r_den == '0 || r_num <= 0) n_t = '0;
                else if (r_num >= r_den) n_t = fpc_pkg::T_ONE;
            end
            fpc_pkg::S_DIV: begin
                n_rem = w_ge ? w_trial[34:0] : {r_rem[33:0], r_nlo[28]};
                n_nlo = {r_nlo[27:0], 1'b0};
                n_quo = {r_quo[27:0], w_ge};
                n_dcnt = r_dcnt - 5'd1;
            end
            fpc_pkg::S_DDONE: begin
                if (!r_mode) begin
                    n_t = r_quo;
                    n_k = '0;
                end else if (!r_axis) begin
                    n_sx = w_pres;
                    n_axis = 1'b1;
                end else begin
                    n_sy = w_pres;
                end
            end
            fpc_pkg::S_LMUL: begin
                n_prod = w_prod;
            end
            fpc_pkg::S_LADD: begin
                n_c.f[r_k] = fpc_pkg::f_sat32(w_sum);
                n_k = r_k + 4'd1;
            end
            fpc_pkg::S_FIX: begin
                case (r_plane)
                    fpc_pkg::PL_XP: n_c.f[0] = r_c.f[2];
                    fpc_pkg::PL_XN: n_c.f[0] = fpc_pkg::f_negsat(r_c.f[2]);
                    fpc_pkg::PL_YP: n_c.f[1] = r_c.f[2];
                    fpc_pkg::PL_YN: n_c.f[1] = fpc_pkg::f_negsat(r_c.f[2]);
                    default:        n_c.f[2] = fpc_pkg::NEAR_Z;
                endcase
            end
            fpc_pkg::S_PUSHC: begin
                n_or = r_or | w_code_c;
                push_en = 1'b1;
                push_b = w_dst;
                push_d = r_c;
                push_d.code = w_code_c;
            end
            fpc_pkg::S_ADV: begin
                n_v = r_w;
                n_i = w_i1;
                if (w_nlast) begin
                    n_buf = w_dst;
                    if (r_plane != fpc_pkg::PL_XP) n_plane = r_plane - 3'd1;
                end
            end
            fpc_pkg::S_OSTART: begin
                n_i = '0;
                n_n = (32'(w_n0) < OUT_LIMIT) ? w_n0 : CW'(OUT_LIMIT);
            end
            fpc_pkg::S_ORD: begin
                w_raddr = f_addr(r_buf, r_i[IW-1:0]);
            end
            fpc_pkg::S_OGET: begin
                n_v = r_rd;
            end
            fpc_pkg::S_OX: begin
                n_axis = 1'b0;
                n_sx = '0;
                n_sy = '0;
            end
            fpc_pkg::S_PMUL: begin
                n_prod = w_prod;
                n_neg = w_sel[31];
            end
            fpc_pkg::S_PLOAD: begin
                n_mode = 1'b1;
                n_rem = {4'd0, r_prod[43:13]};
                n_nlo = {r_prod[12:0], 16'd0};
                n_dvs = {4'd0, w_z[30:0]};
                n_dcnt = fpc_pkg::DIV_LAST;
            end
            fpc_pkg::S_OSEND: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata = {r_sy, r_sx, r_v.f};
                    n_ouser = w_nlast ? fpc_pkg::MARK_LAST : fpc_pkg::MARK_MORE;
                    n_i = w_i1;
                    if (w_nlast) begin
                        n_cnt[0] = '0;
                        n_cnt[1] = '0;
                        n_or = 5'd0;
                        n_and = 5'h1f;
                    end
                end
            end
            fpc_pkg::S_EMPTY: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata = '0;
                    n_ouser = fpc_pkg::MARK_EMPTY;
                    n_cnt[0] = '0;
                    n_cnt[1] = '0;
                    n_or = 5'd0;
                    n_and = 5'h1f;
                end
            end
            default: begin
                n_ovalid = r_ovalid & ~m_axis_tready;
            end
        endcase

        if (push_en && r_cnt[push_b] < CW'(BUF_VERTS)) begin
            w_we = 1'b1;
            w_waddr = f_addr(push_b, r_cnt[push_b][IW-1:0]);
            w_wdata = push_d;
            n_cnt[push_b] = r_cnt[push_b] + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpc_pkg::S_IDLE;
            r_hw <= fpc_pkg::HALF_WIDTH_RST;
            r_hh <= fpc_pkg::HALF_HEIGHT_RST;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_or <= 5'd0;
            r_and <= 5'h1f;
            r_buf <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_or <= n_or;
            r_and <= n_and;
            r_buf <= n_buf;
            r_ovalid <= n_ovalid;
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == fpc_pkg::REG_HALF_WIDTH) r_hw <= pwdata[11:0];
                else r_hh <= pwdata[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_plane <= n_plane;
        r_i <= n_i;
        r_n <= n_n;
        r_k <= n_k;
        r_mode <= n_mode;
        r_axis <= n_axis;
        r_neg <= n_neg;
        r_dcnt <= n_dcnt;
        r_v <= n_v;
        r_w <= n_w;
        r_first <= n_first;
        r_c <= n_c;
        r_num <= n_num;
        r_den <= n_den;
        r_t <= n_t;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_nlo <= n_nlo;
        r_quo <= n_quo;
        r_prod <= n_prod;
        r_sx <= n_sx;
        r_sy <= n_sy;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

endmodule
